@@ sv/h2d_pkg.sv @@
package h2d_pkg;

  localparam int unsigned CfgDataW   = 32;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned BinCntRegW = 7;
  localparam int unsigned TotalW     = 48;
  localparam int unsigned OutCountW  = 32;
  localparam int unsigned BinIdxW    = 6;

  localparam logic [1:0] MODE_BIN   = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [CfgDataW-1:0]   SCALE_RESET     = 32'd65536;
  localparam logic [BinCntRegW-1:0] BIN_COUNT_RESET = 7'd64;
  localparam logic [TotalW-1:0]     TOTAL_MAX       = '1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_X_ORIGIN,
    CFG_X_SCALE,
    CFG_X_BIN_COUNT,
    CFG_Y_ORIGIN,
    CFG_Y_SCALE,
    CFG_Y_BIN_COUNT
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_MUL,
    ST_CHECK,
    ST_FETCH,
    ST_WIPE,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    logic [1:0]          mode;
    logic signed [31:0]  x_value;
    logic signed [31:0]  y_value;
    logic [BinIdxW-1:0]  read_x_index;
    logic [BinIdxW-1:0]  read_y_index;
  } h2d_in_t;

  typedef struct packed {
    logic                 in_range;
    logic [BinIdxW-1:0]   x_bin;
    logic [BinIdxW-1:0]   y_bin;
    logic [OutCountW-1:0] bin_count;
    logic [TotalW-1:0]    binned_total;
    logic [TotalW-1:0]    missed_total;
  } h2d_out_t;

  typedef struct packed {
    logic accept;
    logic sel_read;
    logic load_idx;
    logic fetch;
    logic commit;
    logic sweep;
  } h2d_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       sweep_last;
    logic       out_free;
  } h2d_stat_t;

endpackage

@@ sv/h2d_ctrl.sv @@
module h2d_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  h2d_pkg::h2d_stat_t stat_i,
  output h2d_pkg::h2d_cmd_t  cmd_o
);
  import h2d_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.sweep = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (stat_i.mode)
          MODE_BIN:   state_d = ST_MUL;
          MODE_READ:  state_d = ST_CHECK;
          MODE_CLEAR: state_d = ST_WIPE;
          default:    state_d = ST_UPDATE;
        endcase
      end
      ST_MUL: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        cmd_o.load_idx = 1'b1;
        cmd_o.sel_read = (stat_i.mode == MODE_READ);
        state_d        = ST_FETCH;
      end
      ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = ST_UPDATE;
      end
      ST_WIPE: begin
        cmd_o.sweep = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        // The state of this item is only committed once the result has a place to go.
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/h2d_dp.sv @@
module h2d_dp #(
  parameter int unsigned X_BINS      = 64,
  parameter int unsigned Y_BINS      = 64,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  h2d_pkg::h2d_in_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output h2d_pkg::h2d_out_t               out_data_o,
  input  logic                            cfg_we_i,
  input  logic [h2d_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [h2d_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  h2d_pkg::h2d_cmd_t               cmd_i,
  output h2d_pkg::h2d_stat_t              stat_o
);
  import h2d_pkg::*;

  localparam int unsigned Depth = X_BINS * Y_BINS;
  localparam int unsigned XW    = (X_BINS > 1) ? $clog2(X_BINS) : 1;
  localparam int unsigned YW    = (Y_BINS > 1) ? $clog2(Y_BINS) : 1;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;

  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;
  localparam logic [31:0]            XBinsW   = 32'(X_BINS);
  localparam logic [31:0]            YBinsW   = 32'(Y_BINS);
  localparam logic [AW-1:0]          LastAddr = AW'(Depth - 1);

  // Configuration registers
  logic [31:0]            x_origin_q, x_scale_q, y_origin_q, y_scale_q;
  logic [BinCntRegW-1:0]  x_cnt_q, y_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_origin_q <= '0;
      x_scale_q  <= SCALE_RESET;
      x_cnt_q    <= BIN_COUNT_RESET;
      y_origin_q <= '0;
      y_scale_q  <= SCALE_RESET;
      y_cnt_q    <= BIN_COUNT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_X_ORIGIN:    x_origin_q <= cfg_wdata_i;
        CFG_X_SCALE:     x_scale_q  <= cfg_wdata_i;
        CFG_X_BIN_COUNT: x_cnt_q    <= cfg_wdata_i[BinCntRegW-1:0];
        CFG_Y_ORIGIN:    y_origin_q <= cfg_wdata_i;
        CFG_Y_SCALE:     y_scale_q  <= cfg_wdata_i;
        CFG_Y_BIN_COUNT: y_cnt_q    <= cfg_wdata_i[BinCntRegW-1:0];
        default: ;
      endcase
    end
  end

  // Bins in use on each axis: the register, capped by the physical bin count.
  logic [BinCntRegW-1:0] x_lim, y_lim;
  assign x_lim = ({25'd0, x_cnt_q} < XBinsW) ? x_cnt_q : XBinsW[BinCntRegW-1:0];
  assign y_lim = ({25'd0, y_cnt_q} < YBinsW) ? y_cnt_q : YBinsW[BinCntRegW-1:0];

  h2d_in_t item_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q <= in_data_i;
    end
  end

  // Offset stage: 33-bit exact difference, bit 32 marks a negative offset.
  logic [32:0] x_off_q, y_off_q;

  always_ff @(posedge clk_i) begin
    x_off_q <= {item_q.x_value[31], item_q.x_value} - {x_origin_q[31], x_origin_q};
    y_off_q <= {item_q.y_value[31], item_q.y_value} - {y_origin_q[31], y_origin_q};
  end

  // Scale stage: index is the upper word of offset times scale.
  logic [63:0] x_prod, y_prod;
  logic [31:0] x_quot_q, y_quot_q;
  logic        x_neg_q, y_neg_q;

  assign x_prod = 64'(x_off_q[31:0]) * 64'(x_scale_q);
  assign y_prod = 64'(y_off_q[31:0]) * 64'(y_scale_q);

  always_ff @(posedge clk_i) begin
    x_quot_q <= x_prod[63:32];
    y_quot_q <= y_prod[63:32];
    x_neg_q  <= x_off_q[32];
    y_neg_q  <= y_off_q[32];
  end

  // Range check and index select
  logic          x_hit, y_hit, rd_ok;
  logic          hit_d, hit_q;
  logic [XW-1:0] x_idx_d, x_idx_q;
  logic [YW-1:0] y_idx_d, y_idx_q;

  assign x_hit = !x_neg_q && (x_quot_q < {25'd0, x_lim});
  assign y_hit = !y_neg_q && (y_quot_q < {25'd0, y_lim});
  assign rd_ok = ({1'b0, item_q.read_x_index} < x_lim) &&
                 ({1'b0, item_q.read_y_index} < y_lim);

  always_comb begin
    if (cmd_i.sel_read) begin
      hit_d   = rd_ok;
      x_idx_d = rd_ok ? XW'(item_q.read_x_index) : '0;
      y_idx_d = rd_ok ? YW'(item_q.read_y_index) : '0;
    end else begin
      hit_d   = x_hit && y_hit;
      x_idx_d = hit_d ? XW'(x_quot_q) : '0;
      y_idx_d = hit_d ? YW'(y_quot_q) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_idx) begin
      hit_q   <= hit_d;
      x_idx_q <= x_idx_d;
      y_idx_q <= y_idx_d;
    end
  end

  // Bin store
  logic [COUNT_WIDTH-1:0] mem [Depth];
  logic [COUNT_WIDTH-1:0] rdata_q, cnt_new;
  logic [AW-1:0]          rd_addr, addr_q, clr_addr_q;
  logic                   is_bin, wr_en;

  assign rd_addr = AW'(32'(x_idx_q) * Y_BINS + 32'(y_idx_q));
  assign cnt_new = (rdata_q == CountMax) ? rdata_q : rdata_q + 1'b1;
  assign is_bin  = (item_q.mode == MODE_BIN);
  assign wr_en   = cmd_i.commit && is_bin && hit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep) begin
      mem[clr_addr_q] <= '0;
    end else if (wr_en) begin
      mem[addr_q] <= cnt_new;
    end
    if (cmd_i.fetch) begin
      rdata_q <= mem[rd_addr];
      addr_q  <= rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.sweep) begin
      clr_addr_q <= (clr_addr_q == LastAddr) ? '0 : clr_addr_q + 1'b1;
    end
  end

  // Totals
  logic [TotalW-1:0] binned_q, binned_d, missed_q, missed_d;

  always_comb begin
    binned_d = binned_q;
    missed_d = missed_q;
    if (cmd_i.sweep) begin
      binned_d = '0;
      missed_d = '0;
    end else if (cmd_i.commit && is_bin) begin
      if (hit_q) begin
        binned_d = (binned_q == TOTAL_MAX) ? binned_q : binned_q + 1'b1;
      end else begin
        missed_d = (missed_q == TOTAL_MAX) ? missed_q : missed_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      binned_q <= '0;
      missed_q <= '0;
    end else begin
      binned_q <= binned_d;
      missed_q <= missed_d;
    end
  end

  function automatic logic [OutCountW-1:0] clip_count(input logic [COUNT_WIDTH-1:0] c);
    logic [63:0] w;
    w = 64'(c);
    return (w > 64'h0000_0000_FFFF_FFFF) ? '1 : w[OutCountW-1:0];
  endfunction

  h2d_out_t res;

  always_comb begin
    res              = '0;
    res.binned_total = binned_d;
    res.missed_total = missed_d;
    unique case (item_q.mode)
      MODE_BIN: begin
        if (hit_q) begin
          res.in_range  = 1'b1;
          res.x_bin     = BinIdxW'(x_idx_q);
          res.y_bin     = BinIdxW'(y_idx_q);
          res.bin_count = clip_count(cnt_new);
        end
      end
      MODE_READ: begin
        res.in_range  = hit_q;
        res.x_bin     = item_q.read_x_index;
        res.y_bin     = item_q.read_y_index;
        res.bin_count = hit_q ? clip_count(rdata_q) : '0;
      end
      default: ;
    endcase
  end

  // Output register
  logic     out_valid_q;
  h2d_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;
  assign stat_o.mode       = item_q.mode;
  assign stat_o.sweep_last = (clr_addr_q == LastAddr);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

endmodule

@@ sv/two_d_histogram_binner_core.sv @@
// Two-dimensional histogram of signed Q16.16 (x, y) samples.
// Requests enter on in_valid_i/in_ready_o and carry a mode: bin a sample, read
// one bin, or clear every bin and both totals. Each request yields exactly one
// result on out_valid_o/out_ready_i, with the bin, its count and both totals.
// Configuration (origins, scales, bin counts in use) is written through
// cfg_we_i/cfg_index_i/cfg_wdata_i; the user must write it only while no
// request is in flight, as the block itself does not enforce this.
// One request is processed at a time. A clear steps through the bin store,
// which has one write port: it is zeroed one entry per cycle.
// A bin request goes offset, scale multiply, range check, store read, then
// read-modify-write of the bin and the totals.
// After reset the store is zeroed with in_ready_o low; configuration writes
// are taken throughout.
// The result sits in an output register, so the next request is accepted while
// it waits. If the receiver still stalls when the next result is ready, that
// request holds until the register frees up. A bin or read request changes
// no state while it holds, but a clear has by then already zeroed the store
// and both totals.
module two_d_histogram_binner_core #(
  parameter int unsigned X_BINS      = 64,
  parameter int unsigned Y_BINS      = 64,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  h2d_pkg::h2d_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output h2d_pkg::h2d_out_t            out_data_o,
  input  logic                         cfg_we_i,
  input  logic [h2d_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [h2d_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import h2d_pkg::*;

  h2d_cmd_t  cmd;
  h2d_stat_t stat;

  h2d_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  h2d_dp #(
    .X_BINS      (X_BINS),
    .Y_BINS      (Y_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> stat.out_free)
    else $error("result committed into an occupied output register");

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> out_valid_o)
    else $error("committed result not presented");

  a_sweep_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.sweep |-> !in_ready_o && !cmd.commit)
    else $error("store clear overlaps request handling");

endmodule

@@ tb/tb_two_d_histogram_binner_core.sv @@
`timescale 1ns / 100ps

module tb_two_d_histogram_binner_core;
  import h2d_pkg::*;

  localparam int unsigned XBins        = 64;
  localparam int unsigned YBins        = 64;
  localparam int unsigned CountW       = 32;
  localparam int unsigned QOne         = 65536;
  localparam int unsigned DrainCycles  = 16;
  localparam int unsigned StallLimit   = 20000;
  localparam int unsigned PhaseReqs    = 142;
  localparam int unsigned RecentDepth  = 16;

  localparam logic [1:0]          MODE_NOP      = 2'd3;
  localparam logic [CfgIdxW-1:0]  CFG_SPARE_LO  = 3'd6;
  localparam logic [CfgIdxW-1:0]  CFG_SPARE_HI  = 3'd7;
  localparam logic [CountW-1:0]   BIN_MAX       = '1;

  typedef struct {
    logic signed [31:0]    origin;
    logic [31:0]           scale;
    logic [BinCntRegW-1:0] count;
  } axis_cfg_t;

  typedef struct packed {
    logic [BinIdxW-1:0] x;
    logic [BinIdxW-1:0] y;
  } bin_pos_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  h2d_in_t              in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  h2d_out_t             out_data_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_wdata_i = '0;

  // Shadow of the block: axis settings, bin counters and the two totals.
  axis_cfg_t            x_axis;
  axis_cfg_t            y_axis;
  logic [CountW-1:0]    bin_tally [XBins*YBins];
  logic [TotalW-1:0]    binned_sum;
  logic [TotalW-1:0]    missed_sum;

  h2d_in_t              pending_reqs[$];
  h2d_out_t             expected_results[$];
  bin_pos_t             recent_bins[$];

  int unsigned          reqs_queued;
  int unsigned          results_seen;
  int unsigned          mismatches;
  int unsigned          stall_cycles;
  int unsigned          send_idle_pct;
  int unsigned          recv_idle_pct;
  logic                 req_taken;

  two_d_histogram_binner_core #(
    .X_BINS     (XBins),
    .Y_BINS     (YBins),
    .COUNT_WIDTH(CountW)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned axis_limit(logic [BinCntRegW-1:0] count, int unsigned cap);
    return (count < cap) ? count : cap;
  endfunction

  // The offset is formed exactly, so a value just below the origin is a miss
  // rather than a member of bin 0.
  function automatic logic axis_hit(axis_cfg_t ax, int unsigned cap, logic signed [31:0] value,
                                    output logic [BinIdxW-1:0] idx);
    longint      offset;
    logic [63:0] offset_u;
    logic [63:0] product;
    idx = '0;
    offset = longint'(value) - longint'(ax.origin);
    if (offset < 0) return 1'b0;
    offset_u = offset;
    product = offset_u * {32'd0, ax.scale};
    if (product[63:32] >= axis_limit(ax.count, cap)) return 1'b0;
    idx = product[32 +: BinIdxW];
    return 1'b1;
  endfunction

  function automatic h2d_out_t histogram_apply(h2d_in_t req);
    h2d_out_t           res;
    logic [BinIdxW-1:0] xb;
    logic [BinIdxW-1:0] yb;
    logic               x_in;
    logic               y_in;
    int unsigned        addr;
    res = '0;
    case (req.mode)
      MODE_BIN: begin
        x_in = axis_hit(x_axis, XBins, req.x_value, xb);
        y_in = axis_hit(y_axis, YBins, req.y_value, yb);
        if (x_in && y_in) begin
          addr = int'(xb) * YBins + int'(yb);
          if (bin_tally[addr] != BIN_MAX) bin_tally[addr]++;
          if (binned_sum != TOTAL_MAX) binned_sum++;
          res.in_range  = 1'b1;
          res.x_bin     = xb;
          res.y_bin     = yb;
          res.bin_count = bin_tally[addr];
        end else begin
          if (missed_sum != TOTAL_MAX) missed_sum++;
        end
      end
      MODE_READ: begin
        res.x_bin = req.read_x_index;
        res.y_bin = req.read_y_index;
        if (req.read_x_index < axis_limit(x_axis.count, XBins) &&
            req.read_y_index < axis_limit(y_axis.count, YBins)) begin
          res.in_range  = 1'b1;
          res.bin_count = bin_tally[int'(req.read_x_index) * YBins + int'(req.read_y_index)];
        end
      end
      MODE_CLEAR: begin
        foreach (bin_tally[i]) bin_tally[i] = '0;
        binned_sum = '0;
        missed_sum = '0;
      end
      default: ;
    endcase
    res.binned_total = binned_sum;
    res.missed_total = missed_sum;
    return res;
  endfunction

  task automatic check_result(h2d_out_t got);
    h2d_out_t want;
    if (expected_results.size() == 0) begin
      $error("result arrived with no request outstanding");
      mismatches++;
    end else begin
      want = expected_results.pop_front();
      if (got.in_range !== want.in_range) begin
        $error("in_range: expected %0d, got %0d", want.in_range, got.in_range);
        mismatches++;
      end
      if (got.x_bin !== want.x_bin) begin
        $error("x_bin: expected %0d, got %0d", want.x_bin, got.x_bin);
        mismatches++;
      end
      if (got.y_bin !== want.y_bin) begin
        $error("y_bin: expected %0d, got %0d", want.y_bin, got.y_bin);
        mismatches++;
      end
      if (got.bin_count !== want.bin_count) begin
        $error("bin_count: expected %0d, got %0d", want.bin_count, got.bin_count);
        mismatches++;
      end
      if (got.binned_total !== want.binned_total) begin
        $error("binned_total: expected %0d, got %0d", want.binned_total, got.binned_total);
        mismatches++;
      end
      if (got.missed_total !== want.missed_total) begin
        $error("missed_total: expected %0d, got %0d", want.missed_total, got.missed_total);
        mismatches++;
      end
    end
  endtask

  // Inputs change on the falling edge only.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_ni && (!in_valid_i || req_taken)) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data_i  <= pending_reqs.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_taken    <= 1'b0;
      stall_cycles <= 0;
    end else begin
      req_taken <= in_valid_i && in_ready_o;
      if (out_valid_o && out_ready_i) begin
        check_result(out_data_o);
        results_seen++;
      end
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(histogram_apply(in_data_i));
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("** two_d_histogram_binner_core: FAILED **");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_X_ORIGIN:    x_axis.origin = data;
      CFG_X_SCALE:     x_axis.scale  = data;
      CFG_X_BIN_COUNT: x_axis.count  = data[BinCntRegW-1:0];
      CFG_Y_ORIGIN:    y_axis.origin = data;
      CFG_Y_SCALE:     y_axis.scale  = data;
      CFG_Y_BIN_COUNT: y_axis.count  = data[BinCntRegW-1:0];
      default: ;
    endcase
  endtask

  // Bin counts go out with random upper bits; only the low seven are kept.
  task automatic program_axes(axis_cfg_t xa, axis_cfg_t ya);
    logic [CfgDataW-1:0] x_word;
    logic [CfgDataW-1:0] y_word;
    x_word = $urandom();
    y_word = $urandom();
    x_word[BinCntRegW-1:0] = xa.count;
    y_word[BinCntRegW-1:0] = ya.count;
    write_reg(CFG_X_ORIGIN, xa.origin);
    write_reg(CFG_X_SCALE, xa.scale);
    write_reg(CFG_X_BIN_COUNT, x_word);
    write_reg(CFG_Y_ORIGIN, ya.origin);
    write_reg(CFG_Y_SCALE, ya.scale);
    write_reg(CFG_Y_BIN_COUNT, y_word);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (results_seen != reqs_queued) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic queue_req(h2d_in_t req);
    pending_reqs.push_back(req);
    reqs_queued++;
  endtask

  function automatic h2d_in_t make_req(logic [1:0] mode, logic [31:0] x, logic [31:0] y,
                                       logic [BinIdxW-1:0] rx, logic [BinIdxW-1:0] ry);
    h2d_in_t req;
    req.mode         = mode;
    req.x_value      = x;
    req.y_value      = y;
    req.read_x_index = rx;
    req.read_y_index = ry;
    return req;
  endfunction

  function automatic axis_cfg_t random_axis();
    axis_cfg_t ax;
    case ($urandom_range(9))
      0:       ax.origin = 32'sd0;
      1:       ax.origin = 32'h8000_0000;
      2:       ax.origin = 32'h7FFF_FFFF;
      8, 9:    ax.origin = $urandom();
      default: ax.origin = $urandom_range(200 * QOne) - 100 * QOne;
    endcase
    case ($urandom_range(9))
      0:       ax.scale = 32'd0;
      1:       ax.scale = 32'hFFFF_FFFF;
      2, 3:    ax.scale = QOne;
      8, 9:    ax.scale = $urandom();
      default: ax.scale = $urandom_range(1 << 20, 1 << 12);
    endcase
    case ($urandom_range(19))
      0:               ax.count = '0;
      1:               ax.count = BinCntRegW'($urandom_range(127, 65));
      2, 3, 4, 5:      ax.count = 7'd64;
      6, 7, 8, 9, 10:  ax.count = BinCntRegW'($urandom_range(8, 1));
      default:         ax.count = BinCntRegW'($urandom_range(64, 1));
    endcase
    return ax;
  endfunction

  // Mostly values that land in or near the bins in use, with bin edges and
  // values just under the origin mixed in.
  function automatic logic [31:0] pick_coord(axis_cfg_t ax, int unsigned cap);
    logic [63:0] span;
    logic [63:0] bin_edge;
    int unsigned lim;
    int unsigned pick;
    lim  = axis_limit(ax.count, cap);
    pick = $urandom_range(99);
    if (ax.scale == 0) span = 64'hFFFF_FFFF;
    else span = ((64'(lim) + 64'd1) << 32) / ax.scale;
    if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
    if (pick < 70) return ax.origin + $urandom_range(span[31:0]);
    if (pick < 80) return ax.origin - $urandom_range(4, 1);
    if (pick < 92 && ax.scale != 0) begin
      bin_edge = ((64'($urandom_range(lim)) << 32) + ax.scale - 64'd1) / ax.scale;
      return ax.origin + bin_edge[31:0] - 32'd1 + $urandom_range(2);
    end
    return $urandom();
  endfunction

  function automatic h2d_in_t random_req();
    h2d_in_t            req;
    bin_pos_t           spot;
    logic [BinIdxW-1:0] xb;
    logic [BinIdxW-1:0] yb;
    int unsigned        pick;
    req  = make_req(MODE_BIN, $urandom(), $urandom(),
                    BinIdxW'($urandom_range(63)), BinIdxW'($urandom_range(63)));
    pick = $urandom_range(199);
    if (pick < 140) begin
      req.x_value = pick_coord(x_axis, XBins);
      req.y_value = pick_coord(y_axis, YBins);
      if (axis_hit(x_axis, XBins, req.x_value, xb) &&
          axis_hit(y_axis, YBins, req.y_value, yb)) begin
        recent_bins.push_back({xb, yb});
        if (recent_bins.size() > RecentDepth) void'(recent_bins.pop_front());
      end
    end else if (pick < 186) begin
      req.mode = MODE_READ;
      if (recent_bins.size() != 0 && $urandom_range(1) == 0) begin
        spot = recent_bins[$urandom_range(recent_bins.size() - 1)];
        req.read_x_index = spot.x;
        req.read_y_index = spot.y;
      end
    end else if (pick < 196) begin
      req.mode = MODE_NOP;
    end else begin
      req.mode = MODE_CLEAR;
      recent_bins.delete();
    end
    return req;
  endfunction

  initial begin
    axis_cfg_t xa;
    axis_cfg_t ya;
    x_axis = '{origin: 32'sd0, scale: SCALE_RESET, count: BIN_COUNT_RESET};
    y_axis = '{origin: 32'sd0, scale: SCALE_RESET, count: BIN_COUNT_RESET};
    foreach (bin_tally[i]) bin_tally[i] = '0;
    binned_sum    = '0;
    missed_sum    = '0;
    reqs_queued   = 0;
    results_seen  = 0;
    mismatches    = 0;
    send_idle_pct = 13;
    recv_idle_pct = 88;

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Unit bins on x; on y the lowest origin with zero scale folds everything
    // into bin 0, and a count above the array size is capped.
    xa = '{origin: 32'sd0, scale: QOne, count: 7'd64};
    ya = '{origin: 32'h8000_0000, scale: 32'd0, count: 7'd127};
    program_axes(xa, ya);
    queue_req(make_req(MODE_BIN, 32'd0, 32'd0, 6'd0, 6'd0));
    queue_req(make_req(MODE_BIN, 64 * QOne - 1, 32'h7FFF_FFFF, 6'd63, 6'd63));
    queue_req(make_req(MODE_BIN, 64 * QOne, 32'd0, 6'd0, 6'd0));
    queue_req(make_req(MODE_BIN, 32'hFFFF_FFFF, 32'd0, 6'd0, 6'd0));
    queue_req(make_req(MODE_BIN, 32'h8000_0000, 32'd0, 6'd0, 6'd0));
    queue_req(make_req(MODE_BIN, 32'h7FFF_FFFF, 32'h8000_0000, 6'd0, 6'd0));
    queue_req(make_req(MODE_BIN, 5 * QOne + 3, 32'h8000_0000, 6'd0, 6'd0));
    queue_req(make_req(MODE_BIN, 6 * QOne - 1, 32'd0, 6'd0, 6'd0));
    queue_req(make_req(MODE_READ, $urandom(), $urandom(), 6'd5, 6'd0));
    queue_req(make_req(MODE_READ, $urandom(), $urandom(), 6'd63, 6'd63));
    queue_req(make_req(MODE_READ, $urandom(), $urandom(), 6'd0, 6'd0));
    queue_req(make_req(MODE_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 6'd63));
    queue_req(make_req(MODE_CLEAR, $urandom(), $urandom(), 6'd5, 6'd0));
    queue_req(make_req(MODE_READ, $urandom(), $urandom(), 6'd5, 6'd0));
    queue_req(make_req(MODE_BIN, QOne, -32'sd7, 6'd0, 6'd0));
    drain();

    // Highest origin and scale with a single x bin; no y bins at all.
    xa = '{origin: 32'h7FFF_FFFF, scale: 32'hFFFF_FFFF, count: 7'd1};
    ya = '{origin: 32'sd100, scale: 3 * QOne, count: 7'd0};
    program_axes(xa, ya);
    write_reg(CFG_SPARE_LO, $urandom());
    write_reg(CFG_SPARE_HI, $urandom());
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    queue_req(make_req(MODE_BIN, 32'h7FFF_FFFF, 32'd100, 6'd0, 6'd0));
    queue_req(make_req(MODE_BIN, 32'h7FFF_FFFE, 32'd100, 6'd0, 6'd0));
    queue_req(make_req(MODE_READ, 32'd0, 32'd0, 6'd0, 6'd0));
    queue_req(make_req(MODE_READ, 32'd0, 32'd0, 6'd63, 6'd63));
    drain();

    // No x bins, while y has the highest origin and scale.
    xa = '{origin: 32'h8000_0000, scale: 32'd0, count: 7'd0};
    ya = '{origin: 32'h7FFF_FFFF, scale: 32'hFFFF_FFFF, count: 7'd64};
    program_axes(xa, ya);
    queue_req(make_req(MODE_BIN, 32'd0, 32'h7FFF_FFFF, 6'd0, 6'd0));
    queue_req(make_req(MODE_READ, 32'd0, 32'd0, 6'd0, 6'd0));
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 2) begin
        send_idle_pct = 88;
        recv_idle_pct = 13;
      end else if (phase == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      recent_bins.delete();
      program_axes(random_axis(), random_axis());
      repeat (PhaseReqs) queue_req(random_req());
      drain();
    end

    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("** two_d_histogram_binner_core: PASSED **");
    end else begin
      $display("** two_d_histogram_binner_core: FAILED **");
    end
    $finish;
  end

endmodule
